// ----- rtl/sndta_pkg.sv -----
package sndta_pkg;

  // Value format
  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned INT_BITS  = VALUE_W - FRAC_BITS;

  // Fraction digit count and the widths that follow from it
  localparam int unsigned MAX_FRAC_DIGITS = 15;
  localparam int unsigned DIGITS_W        = 4;
  localparam int unsigned Q_W             = 50;
  localparam int unsigned PROD_W          = FRAC_BITS + Q_W;
  localparam int unsigned INT_DIGITS      = 10;
  localparam int unsigned INT_BCD_W       = 4 * INT_DIGITS;
  localparam int unsigned FRAC_BCD_W      = 4 * MAX_FRAC_DIGITS;
  localparam int unsigned CONV_STEPS      = Q_W;
  localparam int unsigned CNT_W           = 6;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 4'd6;

  // Character codes
  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;

  // One converted number, as handed from the front to the back
  typedef struct packed {
    logic                  neg;
    logic [INT_BCD_W-1:0]  int_bcd;
    logic [FRAC_BCD_W-1:0] frac_bcd;
    logic [DIGITS_W-1:0]   digits;
  } entry_t;

  // One shift-and-add-3 step of a binary to BCD conversion.
  function automatic logic [FRAC_BCD_W-1:0] dabble_step(logic [FRAC_BCD_W-1:0] b,
                                                        logic bit_in);
    logic [FRAC_BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
      if (a[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[FRAC_BCD_W-2:0], bit_in};
  endfunction

endpackage

// ----- rtl/sndta_front.sv -----
module sndta_front import sndta_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic [DIGITS_W-1:0]        digits_i,
  input  logic                       full_i,
  output logic                       push_o,
  output entry_t                     entry_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCALE, ST_ROUND, ST_FIX, ST_CONV, ST_DONE
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  neg_q;
  logic [DIGITS_W-1:0]   digits_q;
  logic [PROD_W-1:0]     prod_q;
  logic [Q_W-1:0]        scale_q;
  logic [Q_W-1:0]        q_q;
  logic [INT_BITS-1:0]   ipart_q;
  logic [Q_W-1:0]        ib_q;
  logic [Q_W-1:0]        qb_q;
  logic [INT_BCD_W-1:0]  int_bcd_q;
  logic [FRAC_BCD_W-1:0] frac_bcd_q;

  logic [VALUE_W-1:0]    v_u;
  logic [VALUE_W-1:0]    mag;
  logic [PROD_W-1:0]     round_sum;
  logic                  carry;
  logic [Q_W-1:0]        q_fix;
  logic [INT_BITS-1:0]   ipart_fix;
  logic [FRAC_BCD_W-1:0] int_step;

  // Magnitude of the incoming value, exact also for the most negative one.
  assign v_u = value_i;
  assign mag = v_u[VALUE_W-1] ? (~v_u + VALUE_W'(1)) : v_u;

  // Rounding: add one half LSB, then fold a fraction overflow into the integer.
  assign round_sum = prod_q + (PROD_W'(1) << (FRAC_BITS - 1));
  assign carry     = (q_q >= scale_q);
  assign q_fix     = carry ? (q_q - scale_q) : q_q;
  assign ipart_fix = carry ? (ipart_q + INT_BITS'(1)) : ipart_q;

  assign int_step = dabble_step(FRAC_BCD_W'(int_bcd_q), ib_q[Q_W-1]);

  assign busy    = (state_q != ST_IDLE);
  assign push_o  = (state_q == ST_DONE) && !full_i;
  assign entry_o = '{neg: neg_q, int_bcd: int_bcd_q, frac_bcd: frac_bcd_q,
                     digits: digits_q};

  // Sequencer: scale the fraction, round, then convert both parts to BCD.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            neg_q    <= v_u[VALUE_W-1];
            ipart_q  <= mag[VALUE_W-1:FRAC_BITS];
            prod_q   <= PROD_W'(mag[FRAC_BITS-1:0]);
            scale_q  <= Q_W'(1);
            digits_q <= (digits_i > DIGITS_W'(MAX_FRAC_DIGITS)) ?
                        DIGITS_W'(MAX_FRAC_DIGITS) : digits_i;
            cnt_q    <= '0;
            state_q  <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (cnt_q == CNT_W'(digits_q)) begin
            state_q <= ST_ROUND;
          end else begin
            prod_q  <= (prod_q << 3) + (prod_q << 1);
            scale_q <= (scale_q << 3) + (scale_q << 1);
            cnt_q   <= cnt_q + CNT_W'(1);
          end
        end
        ST_ROUND: begin
          q_q     <= round_sum[PROD_W-1:FRAC_BITS];
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          neg_q      <= neg_q && ((ipart_fix != '0) || (q_fix != '0));
          ib_q       <= Q_W'(ipart_fix);
          qb_q       <= q_fix;
          int_bcd_q  <= '0;
          frac_bcd_q <= '0;
          cnt_q      <= '0;
          state_q    <= ST_CONV;
        end
        ST_CONV: begin
          int_bcd_q  <= int_step[INT_BCD_W-1:0];
          frac_bcd_q <= dabble_step(frac_bcd_q, qb_q[Q_W-1]);
          ib_q       <= ib_q << 1;
          qb_q       <= qb_q << 1;
          cnt_q      <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(CONV_STEPS - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sndta_queue.sv -----
module sndta_queue import sndta_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t entry_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  // Storage for two converted numbers.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- rtl/sndta_back.sv -----
module sndta_back import sndta_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  entry_t            entry_i,
  output logic              pop_o,
  output logic              char_valid_o,
  output logic [CHAR_W-1:0] char_code_o,
  output logic              last_char_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SIGN, ST_INT, ST_POINT, ST_FRAC
  } state_e;

  state_e              state_q;
  entry_t              entry_q;
  logic [3:0]          idx_q;
  logic                valid_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;
  logic [3:0]          top_idx;
  logic [3:0]          int_digit;
  logic [3:0]          frac_digit;

  // Highest nonzero integer digit of the waiting entry, zero if none.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (entry_i.int_bcd[4*i +: 4] != 4'd0) begin
        top_idx = 4'(i);
      end
    end
  end

  assign int_digit  = entry_q.int_bcd[idx_q*4 +: 4];
  assign frac_digit = entry_q.frac_bcd[idx_q*4 +: 4];
  assign pop_o      = (state_q == ST_IDLE) && !empty_i;

  assign char_valid_o = valid_q;
  assign char_code_o  = char_q;
  assign last_char_o  = last_q;

  // Character sequencer: sign, integer digits, point, fraction digits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            entry_q <= entry_i;
            idx_q   <= top_idx;
            state_q <= entry_i.neg ? ST_SIGN : ST_INT;
          end
        end
        ST_SIGN: begin
          valid_q <= 1'b1;
          char_q  <= CH_MINUS;
          state_q <= ST_INT;
        end
        ST_INT: begin
          valid_q <= 1'b1;
          char_q  <= CH_ZERO + CHAR_W'(int_digit);
          if (idx_q == 4'd0) begin
            if (entry_q.digits == '0) begin
              last_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_POINT;
            end
          end else begin
            idx_q <= idx_q - 4'd1;
          end
        end
        ST_POINT: begin
          valid_q <= 1'b1;
          char_q  <= CH_POINT;
          idx_q   <= entry_q.digits - DIGITS_W'(1);
          state_q <= ST_FRAC;
        end
        ST_FRAC: begin
          valid_q <= 1'b1;
          char_q  <= CH_ZERO + CHAR_W'(frac_digit);
          if (idx_q == 4'd0) begin
            last_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q - 4'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (char_q == CH_MINUS) |-> !last_q)
    else $error("minus sign flagged as last character");

  a_point_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (char_q == CH_POINT) |-> !last_q ##1 valid_q)
    else $error("decimal point not followed by a digit");

  a_text_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |=> valid_q)
    else $error("gap inside the text of one number");
`endif

endmodule

// ----- rtl/signed_number_to_decimal_ascii_unit.sv -----
// Channel   Direction  Handshake                      Payload
// input     in         start, busy (taken: start&!busy) value_i
// config    in         cfg_valid_i, cfg_ready_o       cfg_data_i (fraction digits)
// result    out        char_valid_o (one cycle)       char_code_o, last_char_o
//
// The front converts a number with d fraction digits in d scaling steps, a
// count check, a rounding step, a carry step, 50 shift steps of the BCD
// converter, a hand-over step that waits while the queue is full, and the idle
// step that takes a number. The back fetches one, then sends a character a cycle.
// A two-entry queue lets the front convert while the back is still sending.
// Reset is asynchronous and active low; fraction digits resets to six.
// Results cannot be held off; busy stays high while the front is working.
module signed_number_to_decimal_ascii_unit import sndta_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [DIGITS_W-1:0]       cfg_data_i,
  output logic                      char_valid_o,
  output logic [CHAR_W-1:0]         char_code_o,
  output logic                      last_char_o
);

  logic [DIGITS_W-1:0] digits_q;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  entry_t              push_entry;
  entry_t              pop_entry;

  assign cfg_ready_o = 1'b1;

  // Fraction digit count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= DIGITS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      digits_q <= cfg_data_i;
    end
  end

  sndta_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .value_i  (value_i),
    .digits_i (digits_q),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  sndta_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  sndta_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

endmodule
